// File: design/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg: shared definitions for the touch gesture classifier
// register indexes, gesture codes, register reset values and field widths
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  // coordinate width default, legal range 8..16
  localparam int unsigned CoordBitsDef = 12;

  localparam int unsigned TimeBits    = 32;
  localparam int unsigned MsBits      = 16;
  localparam int unsigned PixBits     = 12;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned GestBits    = 3;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegLongPressMs   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegSwipeThresh   = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegTapTimeoutMs  = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegHoldTolerance = 2'd3;

  // register reset values
  localparam logic [MsBits-1:0]  LongPressMsRst   = 16'd800;
  localparam logic [PixBits-1:0] SwipeThreshRst   = 12'd50;
  localparam logic [MsBits-1:0]  TapTimeoutMsRst  = 16'd300;
  localparam logic [PixBits-1:0] HoldToleranceRst = 12'd20;

  // gesture codes
  localparam logic [GestBits-1:0] GestNone  = 3'd0;
  localparam logic [GestBits-1:0] GestLong  = 3'd1;
  localparam logic [GestBits-1:0] GestRight = 3'd2;
  localparam logic [GestBits-1:0] GestLeft  = 3'd3;
  localparam logic [GestBits-1:0] GestDown  = 3'd4;
  localparam logic [GestBits-1:0] GestUp    = 3'd5;
  localparam logic [GestBits-1:0] GestTap   = 3'd6;

endpackage

`default_nettype wire

// File: design/touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_core: tap, swipe and long-press recognizer
// classifies a stream of touch-panel polls into one gesture code per poll
// ----------------------------------------------------------------------------
// Every accepted poll produces exactly one result transfer carrying a gesture
// code (0 none, 1 long press, 2..5 swipe right/left/down/up, 6 tap). The block
// takes one poll per clock while the input is not stalled: a poll lands in the
// input register, one pass of compare logic against the stored touch-down point
// and time decides the gesture and updates the touch state, and the code goes to
// a result register backed by a one-entry skid stage, or to the skid stage when
// the result register is held by a stalled output. The input stalls only when the
// input register, result register and skid stage are all full. Configuration
// writes must only be issued while no poll is in flight.
`default_nettype none

module touch_gesture_classifier_core #(
  parameter int unsigned COORD_BITS = tgc_pkg::CoordBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [tgc_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [tgc_pkg::CfgDataBits-1:0] cfg_data_i,
  // poll channel
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic                            touched_i,
  input  wire logic [COORD_BITS-1:0]           pos_x_i,
  input  wire logic [COORD_BITS-1:0]           pos_y_i,
  input  wire logic [tgc_pkg::TimeBits-1:0]    now_ms_i,
  // result channel
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [tgc_pkg::GestBits-1:0]    gesture_o
);

  // compare width covers both coordinate offsets and pixel thresholds
  localparam int unsigned CmpW =
    (COORD_BITS > tgc_pkg::PixBits) ? COORD_BITS : tgc_pkg::PixBits;

  // configuration registers
  logic [tgc_pkg::MsBits-1:0]  long_press_ms_q;
  logic [tgc_pkg::PixBits-1:0] swipe_thresh_q;
  logic [tgc_pkg::MsBits-1:0]  tap_timeout_ms_q;
  logic [tgc_pkg::PixBits-1:0] hold_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_ms_q  <= tgc_pkg::LongPressMsRst;
      swipe_thresh_q   <= tgc_pkg::SwipeThreshRst;
      tap_timeout_ms_q <= tgc_pkg::TapTimeoutMsRst;
      hold_tol_q       <= tgc_pkg::HoldToleranceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tgc_pkg::RegLongPressMs:   long_press_ms_q  <= cfg_data_i;
        tgc_pkg::RegSwipeThresh:   swipe_thresh_q   <= cfg_data_i[tgc_pkg::PixBits-1:0];
        tgc_pkg::RegTapTimeoutMs:  tap_timeout_ms_q <= cfg_data_i;
        tgc_pkg::RegHoldTolerance: hold_tol_q       <= cfg_data_i[tgc_pkg::PixBits-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic                         s1_valid_q;
  logic                         s1_touched_q;
  logic [COORD_BITS-1:0]        s1_x_q;
  logic [COORD_BITS-1:0]        s1_y_q;
  logic [tgc_pkg::TimeBits-1:0] s1_now_q;

  // result register and skid stage
  logic                         out_valid_q;
  logic [tgc_pkg::GestBits-1:0] out_gest_q;
  logic                         skid_valid_q;
  logic [tgc_pkg::GestBits-1:0] skid_gest_q;

  logic s1_move;    // classified poll leaves the input register
  logic in_xfer;

  assign s1_move    = s1_valid_q && !skid_valid_q;
  assign in_stall_o = s1_valid_q && skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_touched_q <= touched_i;
      s1_x_q       <= pos_x_i;
      s1_y_q       <= pos_y_i;
      s1_now_q     <= now_ms_i;
    end
  end

  // touch state
  logic                         was_touched_q, was_touched_d;
  logic                         lp_fired_q, lp_fired_d;
  logic [COORD_BITS-1:0]        start_x_q, start_y_q;
  logic [tgc_pkg::TimeBits-1:0] start_time_q;
  logic                         capture_start;

  // offsets and magnitudes against the touch-down point
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0]        ax, ay;
  logic [CmpW-1:0]              ax_w, ay_w, swipe_w, hold_w;
  logic [tgc_pkg::TimeBits-1:0] elapsed;
  logic                         lp_time_ok, tap_time_ok, held_still, is_swipe;
  logic [tgc_pkg::GestBits-1:0] gest;

  always_comb begin
    dx = $signed({1'b0, s1_x_q}) - $signed({1'b0, start_x_q});
    dy = $signed({1'b0, s1_y_q}) - $signed({1'b0, start_y_q});
    // magnitude fits in COORD_BITS since both operands are unsigned COORD_BITS
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    ax_w    = CmpW'(ax);
    ay_w    = CmpW'(ay);
    swipe_w = CmpW'(swipe_thresh_q);
    hold_w  = CmpW'(hold_tol_q);

    // wrapping elapsed time
    elapsed     = s1_now_q - start_time_q;
    lp_time_ok  = elapsed > tgc_pkg::TimeBits'(long_press_ms_q);
    tap_time_ok = elapsed < tgc_pkg::TimeBits'(tap_timeout_ms_q);
    held_still  = (ax_w < hold_w) && (ay_w < hold_w);
    is_swipe    = (ax_w > swipe_w) || (ay_w > swipe_w);

    gest          = tgc_pkg::GestNone;
    was_touched_d = was_touched_q;
    lp_fired_d    = lp_fired_q;
    capture_start = 1'b0;

    priority if (s1_touched_q && !was_touched_q) begin
      // touch-down
      capture_start = 1'b1;
      lp_fired_d    = 1'b0;
      was_touched_d = 1'b1;
    end else if (s1_touched_q) begin
      // held: one long press at most per touch
      if (!lp_fired_q && lp_time_ok && held_still) begin
        lp_fired_d = 1'b1;
        gest       = tgc_pkg::GestLong;
      end
    end else if (was_touched_q) begin
      // release
      was_touched_d = 1'b0;
      if (!lp_fired_q) begin
        if (is_swipe) begin
          // ties go to the vertical axis, zero vertical offset reads as up
          if (ax > ay) begin
            gest = (!dx[COORD_BITS] && (dx != '0)) ? tgc_pkg::GestRight
                                                   : tgc_pkg::GestLeft;
          end else begin
            gest = (!dy[COORD_BITS] && (dy != '0)) ? tgc_pkg::GestDown
                                                   : tgc_pkg::GestUp;
          end
        end else if (tap_time_ok) begin
          gest = tgc_pkg::GestTap;
        end
      end
    end else begin
      // idle poll
      gest = tgc_pkg::GestNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_touched_q <= 1'b0;
      lp_fired_q    <= 1'b0;
      start_x_q     <= '0;
      start_y_q     <= '0;
      start_time_q  <= '0;
    end else if (s1_move) begin
      was_touched_q <= was_touched_d;
      lp_fired_q    <= lp_fired_d;
      if (capture_start) begin
        start_x_q    <= s1_x_q;
        start_y_q    <= s1_y_q;
        start_time_q <= s1_now_q;
      end
    end
  end

  // result register with skid: a result arriving while the output is
  // stalled parks in the skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (s1_move) begin
      if (out_valid_q && out_stall_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_valid_q && !out_stall_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      if (out_valid_q && out_stall_i) begin
        skid_gest_q <= gest;
      end else begin
        out_gest_q <= gest;
      end
    end else if (out_valid_q && !out_stall_i && skid_valid_q) begin
      out_gest_q <= skid_gest_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = out_gest_q;

endmodule

`default_nettype wire

// File: design/tgc_checker.sv
// ----------------------------------------------------------------------------
// tgc_checker: port-level checks for the touch gesture classifier
// watches the poll and result channels and the gesture codes
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_checker #(
  parameter int unsigned COORD_BITS = tgc_pkg::CoordBitsDef
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic [COORD_BITS-1:0]        pos_x_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [tgc_pkg::GestBits-1:0] gesture_o
);

  // input only backs up when results are waiting downstream
  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // a fresh result traces back to an input transfer through the input register
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a matching poll");

  // only defined gesture codes leave the block
  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gesture_o != 3'd7))
    else $error("undefined gesture code");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(gesture_o)))
    else $error("stalled result changed");

  // coordinate width sanity, keeps the parameter tied to the port it sizes
  a_coord_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ($bits(pos_x_i) == COORD_BITS))
    else $error("coordinate port width mismatch");

endmodule

bind touch_gesture_classifier_core tgc_checker #(
  .COORD_BITS(COORD_BITS)
) u_tgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .pos_x_i     (pos_x_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .gesture_o   (gesture_o)
);

`default_nettype wire

// File: verif/tb_touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_touch_gesture_classifier_core: self-checking bench for the gesture core
// feeds touch polls (directed gestures, then random touch sequences and noise)
// through the poll channel with random gaps and result back-pressure, predicts
// one gesture code per poll and compares every result transfer in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_touch_gesture_classifier_core;

  localparam int unsigned CoordW   = tgc_pkg::CoordBitsDef;
  localparam int          CoordMax = (1 << CoordW) - 1;
  localparam int          NumPhases = 8;
  localparam int          PhasePolls = 225;

  // --------------------------------------------------------------------------
  // gesture predictor with its own copy of registers and touch state,
  // holding the gesture codes still owed by the block
  // --------------------------------------------------------------------------
  class gesture_board;
    logic [tgc_pkg::MsBits-1:0]   long_press_ms;
    logic [tgc_pkg::PixBits-1:0]  swipe_limit;
    logic [tgc_pkg::MsBits-1:0]   tap_timeout_ms;
    logic [tgc_pkg::PixBits-1:0]  hold_tolerance;
    bit                           was_touched;
    bit                           long_press_fired;
    logic [CoordW-1:0]            start_x;
    logic [CoordW-1:0]            start_y;
    logic [tgc_pkg::TimeBits-1:0] start_time;
    logic [tgc_pkg::GestBits-1:0] gesture_q[$];
    int                           mismatches;

    function new();
      long_press_ms    = tgc_pkg::LongPressMsRst;
      swipe_limit      = tgc_pkg::SwipeThreshRst;
      tap_timeout_ms   = tgc_pkg::TapTimeoutMsRst;
      hold_tolerance   = tgc_pkg::HoldToleranceRst;
      was_touched      = 1'b0;
      long_press_fired = 1'b0;
      start_x          = '0;
      start_y          = '0;
      start_time       = '0;
      mismatches       = 0;
    endfunction

    function void write_reg(logic [tgc_pkg::CfgIdxBits-1:0] idx,
                            logic [tgc_pkg::CfgDataBits-1:0] data);
      case (idx)
        tgc_pkg::RegLongPressMs:   long_press_ms  = data[tgc_pkg::MsBits-1:0];
        tgc_pkg::RegSwipeThresh:   swipe_limit    = data[tgc_pkg::PixBits-1:0];
        tgc_pkg::RegTapTimeoutMs:  tap_timeout_ms = data[tgc_pkg::MsBits-1:0];
        tgc_pkg::RegHoldTolerance: hold_tolerance = data[tgc_pkg::PixBits-1:0];
        default: ;
      endcase
    endfunction

    // classify one accepted poll and queue the gesture it should produce
    function void note_poll(bit touched, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [tgc_pkg::TimeBits-1:0] now);
      logic [tgc_pkg::GestBits-1:0] g;
      logic [tgc_pkg::TimeBits-1:0] held;
      int                           dx;
      int                           dy;
      int                           ax;
      int                           ay;
      g    = tgc_pkg::GestNone;
      // elapsed time wraps mod 2^32, a timestamp going backwards looks huge
      held = now - start_time;
      dx   = int'(x) - int'(start_x);
      dy   = int'(y) - int'(start_y);
      ax   = (dx < 0) ? -dx : dx;
      ay   = (dy < 0) ? -dy : dy;
      if (touched && !was_touched) begin
        start_x          = x;
        start_y          = y;
        start_time       = now;
        long_press_fired = 1'b0;
        was_touched      = 1'b1;
      end else if (touched) begin
        if (!long_press_fired && held > tgc_pkg::TimeBits'(long_press_ms) &&
            ax < int'(hold_tolerance) && ay < int'(hold_tolerance)) begin
          long_press_fired = 1'b1;
          g = tgc_pkg::GestLong;
        end
      end else if (was_touched) begin
        was_touched = 1'b0;
        // nothing reported on the release that ends a long press
        if (!long_press_fired) begin
          if (ax > int'(swipe_limit) || ay > int'(swipe_limit)) begin
            // tie goes to the vertical axis
            if (ax > ay) g = (dx > 0) ? tgc_pkg::GestRight : tgc_pkg::GestLeft;
            else         g = (dy > 0) ? tgc_pkg::GestDown : tgc_pkg::GestUp;
          end else if (held < tgc_pkg::TimeBits'(tap_timeout_ms)) begin
            g = tgc_pkg::GestTap;
          end
        end
      end
      gesture_q.push_back(g);
    endfunction

    function void check_gesture(logic [tgc_pkg::GestBits-1:0] got);
      logic [tgc_pkg::GestBits-1:0] want;
      if (gesture_q.size() == 0) begin
        mismatches++;
        $display("%0t: gesture %0d transferred with nothing expected", $time, got);
      end else begin
        want = gesture_q.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: gesture mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return gesture_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block signals
  // --------------------------------------------------------------------------
  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [tgc_pkg::CfgIdxBits-1:0]  cfg_index_i;
  logic [tgc_pkg::CfgDataBits-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic                            touched_i;
  logic [CoordW-1:0]               pos_x_i;
  logic [CoordW-1:0]               pos_y_i;
  logic [tgc_pkg::TimeBits-1:0]    now_ms_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [tgc_pkg::GestBits-1:0]    gesture_o;

  touch_gesture_classifier_core #(
    .COORD_BITS(CoordW)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .touched_i   (touched_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gesture_o   (gesture_o)
  );

  gesture_board                 board;
  int                           polls_sent;
  bit                           steady;     // no gaps and no stalls on either side
  bit                           hold_req;   // asks the receiver for one long hold-off
  logic [tgc_pkg::TimeBits-1:0] ms_clock;   // running timestamp between touch sequences

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous cap: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // offer one poll after a random gap and wait for its transfer; valid stays
  // high across back-to-back polls instead of dropping for a step
  task automatic send_poll(input bit touched, input int x, input int y,
                           input logic [tgc_pkg::TimeBits-1:0] now);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    touched_i  <= touched;
    pos_x_i    <= CoordW'(x);
    pos_y_i    <= CoordW'(y);
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_poll(touched, CoordW'(x), CoordW'(y), now);
    polls_sent++;
  endtask

  // register write only with the block drained; every poll yields a result,
  // so an empty queue means nothing is in flight
  task automatic set_reg(input logic [tgc_pkg::CfgIdxBits-1:0] idx, input int value);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= tgc_pkg::CfgDataBits'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, tgc_pkg::CfgDataBits'(value));
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > CoordMax) ? CoordMax : v);
  endfunction

  // start points lean toward the panel edges
  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return CoordMax;
      default: return $urandom_range(0, CoordMax);
    endcase
  endfunction

  // signed offset clustered around a pixel limit (tolerance or threshold)
  function automatic int drift(int limit);
    int mag;
    case ($urandom_range(0, 4))
      0:       mag = 0;
      1:       mag = (limit > 0) ? $urandom_range(0, limit - 1) : 0;
      2:       mag = limit - 1 + $urandom_range(0, 2);
      3:       mag = $urandom_range(0, CoordMax);
      default: mag = (limit > 0) ? $urandom_range(0, limit) : $urandom_range(0, 3);
    endcase
    if (mag < 0) mag = 0;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // elapsed time clustered around a millisecond limit, sometimes backwards
  function automatic logic [tgc_pkg::TimeBits-1:0] elapsed_near(int limit);
    case ($urandom_range(0, 4))
      0:       return tgc_pkg::TimeBits'(limit - 1 + $urandom_range(0, 2));
      1:       return tgc_pkg::TimeBits'($urandom_range(0, 2 * limit + 10));
      2:       return $urandom();
      3:       return tgc_pkg::TimeBits'($urandom_range(0, 50));
      default: return tgc_pkg::TimeBits'(limit + $urandom_range(1, 100));
    endcase
  endfunction

  // one touch: down, a few held polls, release with a swipe-sized offset or not
  task automatic touch_sequence();
    int                           x0;
    int                           y0;
    int                           ox;
    int                           oy;
    int                           held_polls;
    logic [tgc_pkg::TimeBits-1:0] t0;
    logic [tgc_pkg::TimeBits-1:0] el;
    x0 = pick_coord();
    y0 = pick_coord();
    // some touches straddle the timestamp wrap
    t0 = ($urandom_range(0, 9) == 0) ? ~tgc_pkg::TimeBits'($urandom_range(0, 3000))
                                     : ms_clock;
    send_poll(1'b1, x0, y0, t0);
    held_polls = $urandom_range(0, 4);
    for (int i = 0; i < held_polls; i++) begin
      ox = drift(int'(board.hold_tolerance));
      oy = drift(int'(board.hold_tolerance));
      el = elapsed_near(int'(board.long_press_ms));
      send_poll(1'b1, clamp_coord(x0 + ox), clamp_coord(y0 + oy), t0 + el);
    end
    ox = drift(int'(board.swipe_limit));
    oy = drift(int'(board.swipe_limit));
    // equal magnitudes exercise the vertical tie-break
    if ($urandom_range(0, 5) == 0) oy = $urandom_range(0, 1) ? ox : -ox;
    el = elapsed_near(int'(board.tap_timeout_ms));
    send_poll(1'b0, clamp_coord(x0 + ox), clamp_coord(y0 + oy), t0 + el);
    ms_clock = t0 + el + tgc_pkg::TimeBits'($urandom_range(1, 5000));
  endtask

  // one random poll: stray releases, re-touches without release, odd times
  task automatic noise_poll();
    send_poll($urandom_range(0, 1), $urandom_range(0, CoordMax),
              $urandom_range(0, CoordMax), $urandom());
  endtask

  // register settings per phase: reset values, extremes, random ones, then reset values
  task automatic configure_phase(input int phase);
    if (phase == 1) begin
      set_reg(tgc_pkg::RegLongPressMs, 0);
      set_reg(tgc_pkg::RegSwipeThresh, 0);
      set_reg(tgc_pkg::RegTapTimeoutMs, 0);
      set_reg(tgc_pkg::RegHoldTolerance, 0);
    end else if (phase == 2) begin
      // all ones also sets the upper data bits that the pixel registers drop
      set_reg(tgc_pkg::RegLongPressMs, 16'hFFFF);
      set_reg(tgc_pkg::RegSwipeThresh, 16'hFFFF);
      set_reg(tgc_pkg::RegTapTimeoutMs, 16'hFFFF);
      set_reg(tgc_pkg::RegHoldTolerance, 16'hFFFF);
    end else if (phase == NumPhases - 1) begin
      set_reg(tgc_pkg::RegLongPressMs, tgc_pkg::LongPressMsRst);
      set_reg(tgc_pkg::RegSwipeThresh, tgc_pkg::SwipeThreshRst);
      set_reg(tgc_pkg::RegTapTimeoutMs, tgc_pkg::TapTimeoutMsRst);
      set_reg(tgc_pkg::RegHoldTolerance, tgc_pkg::HoldToleranceRst);
    end else if (phase > 0) begin
      set_reg(tgc_pkg::RegLongPressMs,
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1500));
      set_reg(tgc_pkg::RegSwipeThresh,
              ($urandom_range(0, 15) << tgc_pkg::PixBits) | $urandom_range(0, 150));
      set_reg(tgc_pkg::RegTapTimeoutMs, $urandom_range(0, 800));
      set_reg(tgc_pkg::RegHoldTolerance,
              ($urandom_range(0, 15) << tgc_pkg::PixBits) | $urandom_range(0, 60));
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall per transfer, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 80;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      board.check_gesture(gesture_o);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    board       = new();
    polls_sent  = 0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    ms_clock    = tgc_pkg::TimeBits'(1000);
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    touched_i   <= 1'b0;
    pos_x_i     <= '0;
    pos_y_i     <= '0;
    now_ms_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed polls under the reset register values
    // idle poll with every field at its top value
    send_poll(1'b0, CoordMax, CoordMax, 32'hFFFF_FFFF);
    // short touch across the timestamp wrap is a tap
    send_poll(1'b1, 0, 0, 32'hFFFF_FFF0);
    send_poll(1'b0, 0, 0, 32'h0000_0050);
    // hold exactly at the limit, then one past it fires the long press once;
    // the later hold and the release report nothing
    send_poll(1'b1, 100, 100, 1000);
    send_poll(1'b1, 110, 110, 1800);
    send_poll(1'b1, 110, 110, 1801);
    send_poll(1'b1, 100, 100, 5000);
    send_poll(1'b0, 100, 100, 5100);
    // one swipe per direction, each past the threshold
    send_poll(1'b1, 2000, 2000, 0);
    send_poll(1'b0, 2051, 2000, 10);
    send_poll(1'b1, 2000, 2000, 0);
    send_poll(1'b0, 1949, 2000, 10);
    send_poll(1'b1, 2000, 2000, 0);
    send_poll(1'b0, 2000, 2060, 10);
    send_poll(1'b1, 2000, 2000, 0);
    send_poll(1'b0, 2000, 1900, 10);
    // diagonal tie, corner to corner
    send_poll(1'b1, 0, 0, 20);
    send_poll(1'b0, CoordMax, CoordMax, 30);
    // timestamp going backwards while held counts as a long hold
    send_poll(1'b1, 500, 500, 10000);
    send_poll(1'b1, 500, 500, 9999);
    send_poll(1'b0, 500, 500, 10050);
    // offset equal to the tolerance blocks the long press, release too slow for a tap
    send_poll(1'b1, 500, 500, 0);
    send_poll(1'b1, 520, 500, 900);
    send_poll(1'b0, 500, 500, 300);

    // random phases, each under its own register setting
    for (int phase = 0; phase < NumPhases; phase++) begin
      configure_phase(phase);
      steady = (phase == 3 || phase == 4);
      // receiver backs off while the sender keeps pushing, so the input stalls
      if (phase == 4) hold_req = 1'b1;
      while (polls_sent < (phase + 1) * PhasePolls) begin
        if ($urandom_range(0, 6) == 0) noise_poll();
        else touch_sequence();
      end
      // let everything drain once mid-run with no register write after it
      if (phase == 5) begin
        in_valid_i <= 1'b0;
        while (board.pending() != 0) @(posedge clk_i);
      end
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // catch any stray result behind the last one
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/tgc_pkg.sv
design/touch_gesture_classifier_core.sv
design/tgc_checker.sv
verif/tb_touch_gesture_classifier_core.sv
